// ===== rtl/core/local_interrupt_timer_assert.svh =====
// ----------------------------------------------------------------------------
// Local interrupt timer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOCAL_INTERRUPT_TIMER_ASSERT_SVH
`define LOCAL_INTERRUPT_TIMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lit_pkg.sv =====
// ----------------------------------------------------------------------------
// Local interrupt timer package
// Register offsets, field positions, widths and the prescaler decode.
// ----------------------------------------------------------------------------
package lit_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int OFS_W       = 10;
  localparam int VEC_W       = 8;
  localparam int PRE_W       = 7;
  localparam int DIVR_W      = 4;
  localparam int SVR_W       = 9;

  localparam logic [OFS_W-1:0] OFS_EOI = 10'h0B0;
  localparam logic [OFS_W-1:0] OFS_SVR = 10'h0F0;
  localparam logic [OFS_W-1:0] OFS_LVT = 10'h320;
  localparam logic [OFS_W-1:0] OFS_ICR = 10'h380;
  localparam logic [OFS_W-1:0] OFS_CCR = 10'h390;
  localparam logic [OFS_W-1:0] OFS_DCR = 10'h3E0;

  localparam int SVR_EN_BIT   = 8;
  localparam int LVT_MASK_BIT = 16;
  localparam int LVT_PER_BIT  = 17;

  localparam logic [SVR_W-1:0] SVR_RESET = 9'h0FF;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } lit_mode_t;

  // Prescaler period: code {b3,b1,b0} divides by 2^(code+1), code 7 by one.
  function automatic logic [PRE_W:0] lit_divisor(input logic [DIVR_W-1:0] sel);
    logic [2:0] code;
    logic [PRE_W:0] period;
    code = {sel[3], sel[1:0]};
    if (code == 3'd7) begin
      period = (PRE_W+1)'(1);
    end else begin
      period = (PRE_W+1)'(1) << ({1'b0, code} + 4'd1);
    end
    return period;
  endfunction

endpackage

// ===== rtl/core/lit_stream_if.sv =====
// ----------------------------------------------------------------------------
// Local interrupt timer channels
// Valid/ready interfaces for the access stream and the result stream.
// ----------------------------------------------------------------------------
interface lit_in_if
  import lit_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [OFS_W-1:0]  reg_offset;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, mode, reg_offset, write_data, input ready);
  modport sink   (input valid, mode, reg_offset, write_data, output ready);
endinterface

interface lit_out_if
  import lit_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_fire;
  logic [VEC_W-1:0]  irq_vector;
  logic              in_service;

  modport source (output valid, read_data, irq_fire, irq_vector, in_service,
                  input ready);
  modport sink   (input valid, read_data, irq_fire, irq_vector, in_service,
                  output ready);
endinterface

// ===== rtl/core/local_interrupt_timer.sv =====
// ----------------------------------------------------------------------------
// Local interrupt timer
// Down counter with prescaler, timer entry, spurious and divide registers.
// ----------------------------------------------------------------------------
// Every item, a timer tick or a register access, is taken into an input
// register and processed, once the result register is free to be loaded, by
// one pass of logic that updates the timer state and loads the result
// register, so one item is accepted per cycle while the block does not stall.
// The result register decouples the sides: a new item is taken while a
// finished result still waits, and the block stalls only when both the input
// register and the result register are full and the result is not taken.
// The longest path is the counter decrement and zero test.
module local_interrupt_timer
  import lit_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lit_in_if.sink    in_ch,
  lit_out_if.source out_ch
);

  // Input register.
  logic              s1_valid_r;
  logic [1:0]        s1_mode_r;
  logic [OFS_W-1:0]  s1_ofs_r;
  logic [DATA_W-1:0] s1_wdata_r;
  logic              s1_go;

  // Timer state.
  logic [SVR_W-1:0]       svr_r, svr_nxt;
  logic [VEC_W-1:0]       lvt_vec_r, lvt_vec_nxt;
  logic                   lvt_mask_r, lvt_mask_nxt;
  logic                   lvt_per_r, lvt_per_nxt;
  logic [DIVR_W-1:0]      dcr_r, dcr_nxt;
  logic [COUNT_WIDTH-1:0] icr_r, icr_nxt;
  logic [COUNT_WIDTH-1:0] ccr_r, ccr_nxt;
  logic [PRE_W-1:0]       pre_r, pre_nxt;
  logic                   svc_r, svc_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic              fire_r, fire_nxt;
  logic [VEC_W-1:0]  vec_r;
  logic              svc_out_r;

  logic [PRE_W:0]         pre_inc;
  logic [PRE_W:0]         period;
  logic [COUNT_WIDTH-1:0] ccr_dec;
  logic                   sw_en;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  assign pre_inc = {1'b0, pre_r} + (PRE_W+1)'(1);
  assign period  = lit_divisor(dcr_r);
  assign ccr_dec = ccr_r - COUNT_WIDTH'(1);
  assign sw_en   = svr_r[SVR_EN_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_mode_r  <= in_ch.mode;
      s1_ofs_r   <= in_ch.reg_offset;
      s1_wdata_r <= in_ch.write_data;
    end
  end

  always_comb begin
    svr_nxt      = svr_r;
    lvt_vec_nxt  = lvt_vec_r;
    lvt_mask_nxt = lvt_mask_r;
    lvt_per_nxt  = lvt_per_r;
    dcr_nxt      = dcr_r;
    icr_nxt      = icr_r;
    ccr_nxt      = ccr_r;
    pre_nxt      = pre_r;
    svc_nxt      = svc_r;
    rd_nxt       = '0;
    fire_nxt     = 1'b0;
    case (s1_mode_r)
      MODE_TICK: begin
        if (ccr_r != '0) begin
          if (pre_inc < period) begin
            pre_nxt = pre_inc[PRE_W-1:0];
          end else begin
            pre_nxt = '0;
            ccr_nxt = ccr_dec;
            if (ccr_dec == '0) begin
              if (lvt_per_r) begin
                ccr_nxt = icr_r;
              end
              if (!lvt_mask_r && sw_en) begin
                svc_nxt  = 1'b1;
                fire_nxt = 1'b1;
              end
            end
          end
        end
      end
      MODE_WRITE: begin
        case (s1_ofs_r)
          OFS_EOI: begin
            svc_nxt = 1'b0;
          end
          OFS_SVR: begin
            svr_nxt = s1_wdata_r[SVR_W-1:0];
            if (!s1_wdata_r[SVR_EN_BIT]) begin
              lvt_mask_nxt = 1'b1;
            end
          end
          OFS_LVT: begin
            lvt_vec_nxt  = s1_wdata_r[VEC_W-1:0];
            lvt_mask_nxt = s1_wdata_r[LVT_MASK_BIT] || !sw_en;
            lvt_per_nxt  = s1_wdata_r[LVT_PER_BIT];
          end
          OFS_ICR: begin
            icr_nxt = s1_wdata_r[COUNT_WIDTH-1:0];
            ccr_nxt = s1_wdata_r[COUNT_WIDTH-1:0];
            pre_nxt = '0;
          end
          OFS_DCR: begin
            dcr_nxt = {s1_wdata_r[3], 1'b0, s1_wdata_r[1:0]};
          end
          default: begin
          end
        endcase
      end
      MODE_READ: begin
        case (s1_ofs_r)
          OFS_SVR: rd_nxt = DATA_W'(svr_r);
          OFS_LVT: begin
            rd_nxt = '0;
            rd_nxt[VEC_W-1:0]   = lvt_vec_r;
            rd_nxt[LVT_MASK_BIT] = lvt_mask_r;
            rd_nxt[LVT_PER_BIT]  = lvt_per_r;
          end
          OFS_ICR: rd_nxt = DATA_W'(icr_r);
          OFS_CCR: rd_nxt = DATA_W'(ccr_r);
          OFS_DCR: rd_nxt = DATA_W'(dcr_r);
          default: rd_nxt = '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svr_r      <= SVR_RESET;
      lvt_vec_r  <= '0;
      lvt_mask_r <= 1'b1;
      lvt_per_r  <= 1'b0;
      dcr_r      <= '0;
      icr_r      <= '0;
      ccr_r      <= '0;
      pre_r      <= '0;
      svc_r      <= 1'b0;
    end else if (s1_go) begin
      svr_r      <= svr_nxt;
      lvt_vec_r  <= lvt_vec_nxt;
      lvt_mask_r <= lvt_mask_nxt;
      lvt_per_r  <= lvt_per_nxt;
      dcr_r      <= dcr_nxt;
      icr_r      <= icr_nxt;
      ccr_r      <= ccr_nxt;
      pre_r      <= pre_nxt;
      svc_r      <= svc_nxt;
    end
  end

  always_comb begin
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The vector is taken from the entry as it stands; a tick never changes it.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      rd_r      <= rd_nxt;
      fire_r    <= fire_nxt;
      vec_r     <= fire_nxt ? lvt_vec_r : '0;
      svc_out_r <= svc_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = rd_r;
  assign out_ch.irq_fire   = fire_r;
  assign out_ch.irq_vector = vec_r;
  assign out_ch.in_service = svc_out_r;

endmodule

// ===== rtl/core/lit_checker.sv =====
// ----------------------------------------------------------------------------
// Local interrupt timer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "local_interrupt_timer_assert.svh"

module lit_checker
  import lit_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_data,
  input logic              out_irq_fire,
  input logic [VEC_W-1:0]  out_irq_vector,
  input logic              out_in_service
);

  // A delivery always leaves the interrupt in service.
  `LIT_ASSERT_SAME(a_fire_sets_service, out_valid && out_irq_fire, out_in_service, "fire without in-service")

  // No vector is reported without a delivery.
  `LIT_ASSERT_SAME(a_vector_needs_fire, out_valid && !out_irq_fire, out_irq_vector == '0, "vector without fire")

  // A delivery comes from a tick, which never returns read data.
  `LIT_ASSERT_SAME(a_fire_no_read, out_valid && out_irq_fire, out_read_data == '0, "read data on a fire")

  `LIT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind local_interrupt_timer lit_checker u_lit_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_data  (out_ch.read_data),
  .out_irq_fire   (out_ch.irq_fire),
  .out_irq_vector (out_ch.irq_vector),
  .out_in_service (out_ch.in_service)
);
